FILE: rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and codes of the first-fit heap allocator
// Command and status codes, the result item and the sequencer states.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int ADDR_W = 20;
	localparam int REQ_W  = 21;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_ALLOC    = 2'd0,
		STAT_FREED    = 2'd1,
		STAT_NO_ROOM  = 2'd2,
		STAT_BAD_ADDR = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_addr;
		status_t           status;
	} resp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK_CHK,
		S_SPLIT,
		S_MISS,
		S_GROW_CHK,
		S_APPEND,
		S_FIND_CHK,
		S_GET_PREV,
		S_GET_NEXT,
		S_MERGE,
		S_LINK_RD,
		S_LINK_WR,
		S_RESP
	} seq_state_t;

endpackage

FILE: rtl/ffa_hdr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_hdr_mem: block header memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_hdr_mem #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ffa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_seq: allocate / free sequencer
// Walks the block list through the header memory and rewrites headers.
// ----------------------------------------------------------------------------
module ffa_seq #(
	parameter int HEAP_UNITS   = 65536,
	parameter int ALIGN_BYTES  = 16,
	parameter int HEADER_BYTES = 48,
	localparam int IW = $clog2(HEAP_UNITS),
	localparam int LW = IW + 1,
	localparam int CW = $clog2(HEAP_UNITS * ALIGN_BYTES),
	localparam int SW = ((CW > 22) ? CW : 22) + 2,
	localparam int EW = SW + 1 + 2 * LW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         cmd,
	input  logic [ffa_pkg::REQ_W-1:0]    req_size,
	input  logic [ffa_pkg::ADDR_W-1:0]   block_addr,
	output logic                         idle,
	output logic                         resp_valid,
	input  logic                         resp_take,
	output ffa_pkg::resp_t               resp,
	output logic                         mem_re,
	output logic [IW-1:0]                mem_raddr,
	input  logic [EW-1:0]                mem_rdata,
	output logic                         mem_we,
	output logic [IW-1:0]                mem_waddr,
	output logic [EW-1:0]                mem_wdata
);

	localparam int AW   = $clog2(ALIGN_BYTES);
	localparam int HDR  = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int HDRU = HDR / ALIGN_BYTES;
	localparam int CAP  = HEAP_UNITS * ALIGN_BYTES;
	localparam logic [LW-1:0] NIL = LW'(HEAP_UNITS);

	function automatic logic [EW-1:0] pack_ent(logic [SW-1:0] s, logic u,
			logic [LW-1:0] n, logic [LW-1:0] p);
		return {s, u, n, p};
	endfunction

	function automatic logic [ffa_pkg::ADDR_W-1:0] payload_of(logic [LW-1:0] idx);
		logic [SW-1:0] t;
		t = (SW'(idx) << AW) + SW'(HDR);
		return t[ffa_pkg::ADDR_W-1:0];
	endfunction

	ffa_pkg::seq_state_t state_q, state_d;

	logic [SW-1:0] asize_q, asize_d, break_q, break_d;
	logic [LW-1:0] cur_q, cur_d, fidx_q, fidx_d, nw_q, nw_d, last_q, last_d;
	logic [SW-1:0] c_size_q, c_size_d, p_size_q, p_size_d, n_size_q, n_size_d;
	logic [LW-1:0] c_next_q, c_next_d, c_prev_q, c_prev_d;
	logic [LW-1:0] p_prev_q, p_prev_d, n_next_q, n_next_d;
	logic          pf_q, pf_d, nf_q, nf_d;
	logic [LW-1:0] fix_idx_q, fix_idx_d, fix_val_q, fix_val_d;
	logic          fix_prev_q, fix_prev_d;
	ffa_pkg::resp_t resp_q, resp_d;

	logic [SW-1:0] rd_size;
	logic          rd_used;
	logic [LW-1:0] rd_next, rd_prev;

	assign rd_size = mem_rdata[EW-1 -: SW];
	assign rd_used = mem_rdata[2*LW];
	assign rd_next = mem_rdata[2*LW-1 -: LW];
	assign rd_prev = mem_rdata[LW-1:0];

	// Request decode at acceptance.
	logic [SW-1:0] asize_in, addr_w, h_w;
	logic          free_bad;
	logic [LW-1:0] f_idx;

	assign asize_in = ((SW'(req_size) + SW'(ALIGN_BYTES - 1)) >> AW) << AW;
	assign addr_w   = SW'(block_addr);
	assign h_w      = addr_w - SW'(HDR);
	assign free_bad = (addr_w < SW'(HDR)) || (h_w[AW-1:0] != '0) || (h_w >= break_q) ||
		((h_w >> AW) >= SW'(HEAP_UNITS));
	assign f_idx    = LW'(h_w >> AW);

	// Walk, grow and append checks.
	logic          fit, exact, nw_bad, grow_cond, grow_bad, app_bad;
	logic [SW-1:0] nw_sum, need, app_sum;
	logic [LW-1:0] app_idx, prv;

	assign exact     = (rd_size == asize_q);
	assign fit       = !rd_used && (exact || (rd_size >= asize_q + SW'(HDR)));
	assign nw_sum    = SW'(cur_q) + SW'(HDRU) + (asize_q >> AW);
	assign nw_bad    = nw_sum >= SW'(HEAP_UNITS);
	assign grow_cond = !rd_used && (asize_q > rd_size);
	assign need      = asize_q - rd_size;
	assign grow_bad  = (break_q + need) > SW'(CAP);
	assign app_sum   = break_q + asize_q + SW'(HDR);
	assign app_bad   = app_sum > SW'(CAP);
	assign app_idx   = LW'(break_q >> AW);
	assign prv       = (break_q != '0) ? last_q : NIL;

	// Coalescing decision for a free.
	logic          mg_fix;
	logic [LW-1:0] mg_fix_idx;
	always_comb begin
		mg_fix     = 1'b0;
		mg_fix_idx = n_next_q;
		if (pf_q && !nf_q) begin
			mg_fix_idx = c_next_q;
			mg_fix     = (c_next_q != NIL);
		end else if (nf_q) begin
			mg_fix = (n_next_q != NIL);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffa_pkg::S_IDLE: begin
				if (start) begin
					if (cmd == ffa_pkg::CMD_FREE) begin
						state_d = free_bad ? ffa_pkg::S_RESP : ffa_pkg::S_FIND_CHK;
					end else begin
						state_d = (break_q != '0) ? ffa_pkg::S_WALK_CHK : ffa_pkg::S_MISS;
					end
				end
			end
			ffa_pkg::S_WALK_CHK: begin
				if (fit) begin
					state_d = (exact || nw_bad) ? ffa_pkg::S_RESP : ffa_pkg::S_SPLIT;
				end else if (rd_next == NIL) begin
					state_d = ffa_pkg::S_MISS;
				end
			end
			ffa_pkg::S_SPLIT: begin
				state_d = (c_next_q != NIL) ? ffa_pkg::S_LINK_RD : ffa_pkg::S_RESP;
			end
			ffa_pkg::S_MISS: begin
				state_d = (break_q != '0 && last_q != NIL) ? ffa_pkg::S_GROW_CHK :
					ffa_pkg::S_APPEND;
			end
			ffa_pkg::S_GROW_CHK: begin
				state_d = grow_cond ? ffa_pkg::S_RESP : ffa_pkg::S_APPEND;
			end
			ffa_pkg::S_APPEND: begin
				state_d = (!app_bad && prv != NIL) ? ffa_pkg::S_LINK_RD : ffa_pkg::S_RESP;
			end
			ffa_pkg::S_FIND_CHK: begin
				if (cur_q == fidx_q) begin
					if (rd_prev != NIL) begin
						state_d = ffa_pkg::S_GET_PREV;
					end else if (rd_next != NIL) begin
						state_d = ffa_pkg::S_GET_NEXT;
					end else begin
						state_d = ffa_pkg::S_MERGE;
					end
				end else if (rd_next == NIL) begin
					state_d = ffa_pkg::S_RESP;
				end
			end
			ffa_pkg::S_GET_PREV: begin
				state_d = (c_next_q != NIL) ? ffa_pkg::S_GET_NEXT : ffa_pkg::S_MERGE;
			end
			ffa_pkg::S_GET_NEXT: begin
				state_d = ffa_pkg::S_MERGE;
			end
			ffa_pkg::S_MERGE: begin
				state_d = mg_fix ? ffa_pkg::S_LINK_RD : ffa_pkg::S_RESP;
			end
			ffa_pkg::S_LINK_RD: begin
				state_d = ffa_pkg::S_LINK_WR;
			end
			ffa_pkg::S_LINK_WR: begin
				state_d = ffa_pkg::S_RESP;
			end
			ffa_pkg::S_RESP: begin
				if (resp_take) begin
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		asize_d    = asize_q;
		break_d    = break_q;
		cur_d      = cur_q;
		fidx_d     = fidx_q;
		nw_d       = nw_q;
		last_d     = last_q;
		c_size_d   = c_size_q;
		c_next_d   = c_next_q;
		c_prev_d   = c_prev_q;
		p_size_d   = p_size_q;
		p_prev_d   = p_prev_q;
		n_size_d   = n_size_q;
		n_next_d   = n_next_q;
		pf_d       = pf_q;
		nf_d       = nf_q;
		fix_idx_d  = fix_idx_q;
		fix_val_d  = fix_val_q;
		fix_prev_d = fix_prev_q;
		resp_d     = resp_q;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		case (state_q)
			ffa_pkg::S_IDLE: begin
				if (start) begin
					asize_d = asize_in;
					cur_d   = '0;
					if (cmd == ffa_pkg::CMD_FREE) begin
						fidx_d = f_idx;
						resp_d = '{payload_addr: '0, status: ffa_pkg::STAT_BAD_ADDR};
						mem_re = !free_bad;
					end else begin
						mem_re = (break_q != '0);
					end
				end
			end
			ffa_pkg::S_WALK_CHK: begin
				c_next_d = rd_next;
				c_prev_d = rd_prev;
				if (fit) begin
					if (exact) begin
						mem_we    = 1'b1;
						mem_waddr = cur_q[IW-1:0];
						mem_wdata = pack_ent(rd_size, 1'b1, rd_next, rd_prev);
						resp_d    = '{payload_addr: payload_of(cur_q),
							status: ffa_pkg::STAT_ALLOC};
					end else if (nw_bad) begin
						resp_d = '{payload_addr: '0, status: ffa_pkg::STAT_NO_ROOM};
					end else begin
						// Free remainder goes right after the taken block.
						nw_d      = LW'(nw_sum);
						mem_we    = 1'b1;
						mem_waddr = nw_sum[IW-1:0];
						mem_wdata = pack_ent(rd_size - asize_q - SW'(HDR), 1'b0, rd_next, cur_q);
					end
				end else if (rd_next != NIL) begin
					cur_d     = rd_next;
					mem_re    = 1'b1;
					mem_raddr = rd_next[IW-1:0];
				end
			end
			ffa_pkg::S_SPLIT: begin
				mem_we     = 1'b1;
				mem_waddr  = cur_q[IW-1:0];
				mem_wdata  = pack_ent(asize_q, 1'b1, nw_q, c_prev_q);
				resp_d     = '{payload_addr: payload_of(cur_q), status: ffa_pkg::STAT_ALLOC};
				fix_idx_d  = c_next_q;
				fix_prev_d = 1'b1;
				fix_val_d  = nw_q;
				if (last_q == cur_q) begin
					last_d = nw_q;
				end
			end
			ffa_pkg::S_MISS: begin
				if (break_q != '0 && last_q != NIL) begin
					mem_re    = 1'b1;
					mem_raddr = last_q[IW-1:0];
				end
			end
			ffa_pkg::S_GROW_CHK: begin
				if (grow_cond) begin
					if (grow_bad) begin
						resp_d = '{payload_addr: '0, status: ffa_pkg::STAT_NO_ROOM};
					end else begin
						break_d   = break_q + need;
						mem_we    = 1'b1;
						mem_waddr = last_q[IW-1:0];
						mem_wdata = pack_ent(asize_q, 1'b1, rd_next, rd_prev);
						resp_d    = '{payload_addr: payload_of(last_q),
							status: ffa_pkg::STAT_ALLOC};
					end
				end
			end
			ffa_pkg::S_APPEND: begin
				if (app_bad) begin
					resp_d = '{payload_addr: '0, status: ffa_pkg::STAT_NO_ROOM};
				end else begin
					mem_we     = 1'b1;
					mem_waddr  = app_idx[IW-1:0];
					mem_wdata  = pack_ent(asize_q, 1'b1, NIL, prv);
					last_d     = app_idx;
					break_d    = app_sum;
					resp_d     = '{payload_addr: payload_of(app_idx),
						status: ffa_pkg::STAT_ALLOC};
					fix_idx_d  = prv;
					fix_prev_d = 1'b0;
					fix_val_d  = app_idx;
				end
			end
			ffa_pkg::S_FIND_CHK: begin
				c_size_d = rd_size;
				c_next_d = rd_next;
				c_prev_d = rd_prev;
				if (cur_q == fidx_q) begin
					pf_d = 1'b0;
					nf_d = 1'b0;
					if (rd_prev != NIL) begin
						mem_re    = 1'b1;
						mem_raddr = rd_prev[IW-1:0];
					end else if (rd_next != NIL) begin
						mem_re    = 1'b1;
						mem_raddr = rd_next[IW-1:0];
					end
				end else if (rd_next != NIL) begin
					cur_d     = rd_next;
					mem_re    = 1'b1;
					mem_raddr = rd_next[IW-1:0];
				end
			end
			ffa_pkg::S_GET_PREV: begin
				p_size_d = rd_size;
				p_prev_d = rd_prev;
				pf_d     = !rd_used;
				if (c_next_q != NIL) begin
					mem_re    = 1'b1;
					mem_raddr = c_next_q[IW-1:0];
				end
			end
			ffa_pkg::S_GET_NEXT: begin
				n_size_d = rd_size;
				n_next_d = rd_next;
				nf_d     = !rd_used;
			end
			ffa_pkg::S_MERGE: begin
				resp_d     = '{payload_addr: '0, status: ffa_pkg::STAT_FREED};
				mem_we     = 1'b1;
				fix_idx_d  = mg_fix_idx;
				fix_prev_d = 1'b1;
				if (pf_q && nf_q) begin
					// Both neighbors free: the left one swallows this block and the right.
					mem_waddr = c_prev_q[IW-1:0];
					mem_wdata = pack_ent(p_size_q + c_size_q + n_size_q + SW'(2 * HDR),
						1'b0, n_next_q, p_prev_q);
					fix_val_d = c_prev_q;
					if (last_q == c_next_q) begin
						last_d = c_prev_q;
					end
				end else if (pf_q) begin
					mem_waddr = c_prev_q[IW-1:0];
					mem_wdata = pack_ent(p_size_q + SW'(HDR) + c_size_q, 1'b0, c_next_q,
						p_prev_q);
					fix_val_d = c_prev_q;
					if (last_q == fidx_q) begin
						last_d = c_prev_q;
					end
				end else if (nf_q) begin
					mem_waddr = fidx_q[IW-1:0];
					mem_wdata = pack_ent(c_size_q + SW'(HDR) + n_size_q, 1'b0, n_next_q,
						c_prev_q);
					fix_val_d = fidx_q;
					if (last_q == c_next_q) begin
						last_d = fidx_q;
					end
				end else begin
					mem_waddr = fidx_q[IW-1:0];
					mem_wdata = pack_ent(c_size_q, 1'b0, c_next_q, c_prev_q);
				end
			end
			ffa_pkg::S_LINK_RD: begin
				mem_re    = 1'b1;
				mem_raddr = fix_idx_q[IW-1:0];
			end
			ffa_pkg::S_LINK_WR: begin
				mem_we    = 1'b1;
				mem_waddr = fix_idx_q[IW-1:0];
				mem_wdata = fix_prev_q ? pack_ent(rd_size, rd_used, rd_next, fix_val_q) :
					pack_ent(rd_size, rd_used, fix_val_q, rd_prev);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_IDLE;
			break_q <= '0;
			last_q  <= NIL;
		end else begin
			state_q <= state_d;
			break_q <= break_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		asize_q    <= asize_d;
		cur_q      <= cur_d;
		fidx_q     <= fidx_d;
		nw_q       <= nw_d;
		c_size_q   <= c_size_d;
		c_next_q   <= c_next_d;
		c_prev_q   <= c_prev_d;
		p_size_q   <= p_size_d;
		p_prev_q   <= p_prev_d;
		n_size_q   <= n_size_d;
		n_next_q   <= n_next_d;
		pf_q       <= pf_d;
		nf_q       <= nf_d;
		fix_idx_q  <= fix_idx_d;
		fix_val_q  <= fix_val_d;
		fix_prev_q <= fix_prev_d;
		resp_q     <= resp_d;
	end

	assign idle       = (state_q == ffa_pkg::S_IDLE);
	assign resp_valid = (state_q == ffa_pkg::S_RESP);
	assign resp       = resp_q;

endmodule

FILE: rtl/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with coalescing
// Serves allocate and free items over a heap of headered, aligned blocks.
// ----------------------------------------------------------------------------
// The unit handles one item at a time. The walk reads one header from the
// header memory per cycle. An allocate that hits in the first-fit walk
// rewrites the found block's header; a split also writes a header for the
// free remainder. A miss reads the last block to grow it or appends at the
// break. A split or an append that must relink a neighbor also rewrites it.
// A free walks the list from the first block up to the block being freed,
// then reads up to two neighbors and writes back. A rejected free address
// is answered without a header read.
// So the item time is set by the number of blocks in the list, that is by how
// fragmented the heap is.
// Each item yields exactly one result item. The result sits in an output
// register, so a finished result may wait for the consumer while the unit
// returns to idle and takes the next item. The header memory needs no
// clearing after reset: only headers of listed blocks are ever read.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
	parameter int HEAP_UNITS   = 65536,
	parameter int ALIGN_BYTES  = 16,
	parameter int HEADER_BYTES = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [ffa_pkg::REQ_W-1:0]   req_size,
	input  logic [ffa_pkg::ADDR_W-1:0]  block_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ffa_pkg::ADDR_W-1:0]  payload_addr,
	output logic [1:0]                  status
);

	localparam int IW = $clog2(HEAP_UNITS);
	localparam int LW = IW + 1;
	localparam int CW = $clog2(HEAP_UNITS * ALIGN_BYTES);
	localparam int SW = ((CW > 22) ? CW : 22) + 2;
	localparam int EW = SW + 1 + 2 * LW;

	logic           idle, start, resp_valid, resp_take;
	ffa_pkg::resp_t resp, out_resp_q;
	logic           out_valid_q;

	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr;
	logic [EW-1:0] mem_rdata, mem_wdata;

	// A new item is taken only while the sequencer is idle.
	assign in_stall = !idle;
	assign start    = in_valid && idle;

	// The output register can load when it is empty or being drained.
	assign resp_take = !out_valid_q || !out_stall;

	ffa_hdr_mem #(
		.DEPTH (HEAP_UNITS),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ffa_seq #(
		.HEAP_UNITS   (HEAP_UNITS),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.req_size   (req_size),
		.block_addr (block_addr),
		.idle       (idle),
		.resp_valid (resp_valid),
		.resp_take  (resp_take),
		.resp       (resp),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_valid && resp_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_valid && resp_take) begin
			out_resp_q <= resp;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_addr = out_resp_q.payload_addr;
	assign status       = out_resp_q.status;

endmodule

FILE: rtl/ffa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_checker: port-level checks of the heap allocator
// Watches the handshakes and result codes at the top-level ports.
// ----------------------------------------------------------------------------
module ffa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [ffa_pkg::ADDR_W-1:0] payload_addr,
	input logic [1:0]                 status
);

	// A held result keeps its content until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_addr) && $stable(status))
		else $error("result changed while stalled");

	// Work on an accepted item keeps the input side closed in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accepted item");

	// Only a successful allocate reports an address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffa_pkg::STAT_ALLOC |-> payload_addr == '0)
		else $error("address reported with a non-allocate status");

endmodule

bind first_fit_heap_allocator_unit ffa_checker u_ffa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.payload_addr (payload_addr),
	.status       (status)
);
